@@ hw/rtl/wsfd_pkg.sv @@
package wsfd_pkg;

  // widest payload length held by default (full 64-bit extended length)
  localparam int DEFAULT_LEN_BITS = 64;

  // header byte fields
  localparam logic [7:0] RSV_MASK    = 8'h70;
  localparam logic [7:0] LEN7_MASK   = 8'h7F;
  localparam logic [6:0] LEN7_MAX    = 7'd125;
  localparam logic [6:0] LEN7_EXT16  = 7'd126;
  localparam logic [6:0] LEN7_EXT64  = 7'd127;

  // header byte counts still to come
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // one result beat
  typedef struct packed {
    logic [7:0] payload;
    logic       has;
    logic       last;
    logic [3:0] opcode;
    logic       fin;
    logic       err;
  } res_t;

endpackage

@@ hw/rtl/websocket_frame_deframer.sv @@
// Channel  Direction  Handshake           Beat contents
// in       sink       in_valid/in_ready   in_byte, resync
// out      source     out_valid/out_ready payload_byte, has_byte, frame_end,
//                                         frame_opcode, fin_flag, frame_error
//
// One input byte per cycle, sustained while the skid stage is empty. Parsing is
// a single pass of logic between the parser state and the result register.
// A skid stage behind the result register takes the result instead while the
// sink stalls, keeping input open for one extra beat; in_ready drops only when
// both hold a beat. Reset (rst, synchronous) returns the parser to the first
// header byte and empties both result stages.
module websocket_frame_deframer #(
  parameter int LEN_BITS = wsfd_pkg::DEFAULT_LEN_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       resync,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic       has_byte,
  output logic       frame_end,
  output logic [3:0] frame_opcode,
  output logic       fin_flag,
  output logic       frame_error
);

  // parser phases
  localparam logic [2:0] PH_HDR1 = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_ERR  = 3'd5;

  // parser state
  logic [2:0]          phase, phase_next;
  logic [3:0]          hdr_cnt, hdr_cnt_next;
  logic [LEN_BITS-1:0] rem_len, rem_len_next;
  logic                len_ovf, len_ovf_next;    // bits shifted past LEN_BITS
  logic [31:0]         mask_key, mask_key_next;
  logic                is_masked, is_masked_next;
  logic [1:0]          key_index, key_index_next;
  logic [3:0]          held_opcode, held_opcode_next;
  logic                held_fin, held_fin_next;

  // result stages
  wsfd_pkg::res_t res, out_q, skid_q;
  logic           emit;
  logic           skid_valid;

  // working signals
  logic [2:0]          ph;
  logic [6:0]          len7;
  logic [3:0]          cnt_dec;
  logic [LEN_BITS-1:0] rem_shift;
  logic                ovf_shift;
  logic [7:0]          key_byte;
  logic                accept;
  logic                out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = !skid_valid;
  assign out_free = !out_valid || out_ready;

  assign len7      = in_byte[6:0] & wsfd_pkg::LEN7_MASK[6:0];
  assign cnt_dec   = hdr_cnt - 4'd1;
  assign rem_shift = {rem_len[LEN_BITS-9:0], in_byte};
  assign ovf_shift = len_ovf || (|rem_len[LEN_BITS-1 -: 8]);

  always_comb begin
    unique case (key_index)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    ph               = resync ? PH_HDR1 : phase;
    phase_next       = phase;
    hdr_cnt_next     = hdr_cnt;
    rem_len_next     = rem_len;
    len_ovf_next     = len_ovf;
    mask_key_next    = mask_key;
    is_masked_next   = is_masked;
    key_index_next   = key_index;
    held_opcode_next = held_opcode;
    held_fin_next    = held_fin;
    emit             = 1'b0;
    res              = '0;

    unique case (ph)
      PH_ERR: begin
        // halted until resync
      end
      PH_HDR2: begin
        is_masked_next = in_byte[7];
        len_ovf_next   = 1'b0;
        if (len7 <= wsfd_pkg::LEN7_MAX) begin
          rem_len_next = LEN_BITS'(len7);
          if (in_byte[7]) begin
            hdr_cnt_next  = wsfd_pkg::KEY_BYTES;
            mask_key_next = '0;
            phase_next    = PH_KEY;
          end else begin
            key_index_next = 2'd0;
            if (len7 == 7'd0) begin
              phase_next = PH_HDR1;
              emit       = 1'b1;
              res.last   = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end else begin
          rem_len_next = '0;
          hdr_cnt_next = (len7 == wsfd_pkg::LEN7_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                        : wsfd_pkg::EXT64_BYTES;
          phase_next   = PH_EXT;
        end
      end
      PH_EXT: begin
        rem_len_next = rem_shift;
        len_ovf_next = ovf_shift;
        hdr_cnt_next = cnt_dec;
        if (cnt_dec == 4'd0) begin
          if (ovf_shift) begin
            phase_next = PH_ERR;
            emit       = 1'b1;
            res.err    = 1'b1;
          end else if (is_masked) begin
            hdr_cnt_next  = wsfd_pkg::KEY_BYTES;
            mask_key_next = '0;
            phase_next    = PH_KEY;
          end else begin
            key_index_next = 2'd0;
            if (rem_shift == '0) begin
              phase_next = PH_HDR1;
              emit       = 1'b1;
              res.last   = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], in_byte};
        hdr_cnt_next  = cnt_dec;
        if (cnt_dec == 4'd0) begin
          key_index_next = 2'd0;
          if (rem_len == '0) begin
            phase_next = PH_HDR1;
            emit       = 1'b1;
            res.last   = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        key_index_next = key_index + 2'd1;
        rem_len_next   = rem_len - LEN_BITS'(1);
        emit           = 1'b1;
        res.has        = 1'b1;
        res.payload    = is_masked ? (in_byte ^ key_byte) : in_byte;
        if (rem_len == LEN_BITS'(1)) begin
          res.last   = 1'b1;
          phase_next = PH_HDR1;
        end
      end
      default: begin
        // first header byte; unused codes land here too
        held_fin_next    = in_byte[7];
        held_opcode_next = in_byte[3:0];
        hdr_cnt_next     = '0;
        rem_len_next     = '0;
        key_index_next   = 2'd0;
        if ((in_byte & wsfd_pkg::RSV_MASK) != 8'h00) begin
          phase_next = PH_ERR;
          emit       = 1'b1;
          res.err    = 1'b1;
        end else begin
          phase_next = PH_HDR2;
        end
      end
    endcase

    res.opcode = held_opcode_next;
    res.fin    = held_fin_next;
  end

  // parser state update, one byte per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR1;
      hdr_cnt     <= '0;
      rem_len     <= '0;
      len_ovf     <= 1'b0;
      mask_key    <= '0;
      is_masked   <= 1'b0;
      key_index   <= 2'd0;
      held_opcode <= '0;
      held_fin    <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      hdr_cnt     <= hdr_cnt_next;
      rem_len     <= rem_len_next;
      len_ovf     <= len_ovf_next;
      mask_key    <= mask_key_next;
      is_masked   <= is_masked_next;
      key_index   <= key_index_next;
      held_opcode <= held_opcode_next;
      held_fin    <= held_fin_next;
    end
  end

  // result register with skid stage; skid only fills while out is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_q      <= skid_q;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept && emit) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept && emit) begin
      skid_q     <= res;
      skid_valid <= 1'b1;
    end
  end

  assign payload_byte = out_q.payload;
  assign has_byte     = out_q.has;
  assign frame_end    = out_q.last;
  assign frame_opcode = out_q.opcode;
  assign fin_flag     = out_q.fin;
  assign frame_error  = out_q.err;

endmodule

@@ hw/rtl/wsfd_checker.sv @@
module wsfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] payload_byte,
  input logic       has_byte,
  input logic       frame_end,
  input logic       frame_error
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(has_byte)
  ) else $error("result beat changed while stalled");

  // an empty result carries a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> payload_byte == 8'h00
  ) else $error("empty result with nonzero byte");

  // error beats carry neither byte nor frame end
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_error |-> !has_byte && !frame_end
  ) else $error("error beat with byte or end mark");

  // input back-pressure only while a result is waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid
  ) else $error("input blocked with no result pending");

  // nothing shown straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready
  ) else $error("result stages not empty after reset");

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .payload_byte (payload_byte),
  .has_byte     (has_byte),
  .frame_end    (frame_end),
  .frame_error  (frame_error)
);

@@ tb/websocket_frame_deframer_tb.sv @@
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

  // Run limits and stimulus sizes
  localparam int LEN_W        = wsfd_pkg::DEFAULT_LEN_BITS;
  localparam logic [63:0] LEN_CAP = (LEN_W >= 64) ? {64{1'b1}} : ((64'd1 << LEN_W) - 64'd1);
  localparam int RAND_ITEMS   = 1800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 23;
  localparam int CALM_FROM    = 600;   // window with no idling on either side
  localparam int CALM_TO      = 1400;
  localparam int HOLD_AFTER   = 250;   // bytes taken before the long sink stall
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 20;

  // Length forms in the second header byte
  localparam int LEN_SHORT = 0;
  localparam int LEN_EXT16 = 1;
  localparam int LEN_EXT64 = 2;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    HEAD1, HEAD2, EXTLEN, MASKKEY, PAYLOAD, HALTED
  } hdr_phase_e;

  typedef struct packed {
    logic [7:0] b;
    logic       rs;
  } rx_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       resync = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic       frame_end;
  logic [3:0] frame_opcode;
  logic       fin_flag;
  logic       frame_error;

  rx_item_t       stream_q[$];        // bytes still to be offered
  wsfd_pkg::res_t expected_beats[$];  // results predicted but not yet seen

  int  cyc = 0;
  int  mismatches = 0;
  int  bytes_taken = 0;
  logic in_took = 1'b0;         // the byte on the bus went in at the last edge
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  // Predictor state
  hdr_phase_e  phase = HEAD1;
  logic [3:0]  hdr_left = '0;
  logic [63:0] len_left = '0;
  logic [31:0] mask_key = '0;
  logic        masked = 1'b0;
  logic [1:0]  key_pos = '0;
  logic [3:0]  cur_op = '0;
  logic        cur_fin = 1'b0;

  websocket_frame_deframer uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .resync      (resync),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .payload_byte(payload_byte),
    .has_byte    (has_byte),
    .frame_end   (frame_end),
    .frame_opcode(frame_opcode),
    .fin_flag    (fin_flag),
    .frame_error (frame_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void push_result(logic [7:0] b, logic has, logic last, logic err);
    wsfd_pkg::res_t r;
    r.payload = b;
    r.has     = has;
    r.last    = last;
    r.opcode  = cur_op;
    r.fin     = cur_fin;
    r.err     = err;
    expected_beats.insert(expected_beats.size(), r);
  endfunction

  // Header and key complete: either payload follows or the frame ends empty
  function automatic void finish_header();
    key_pos = '0;
    if (len_left == 64'd0) begin
      phase = HEAD1;
      push_result(8'h00, 1'b0, 1'b1, 1'b0);
    end else begin
      phase = PAYLOAD;
    end
  endfunction

  // Length known: read the key if masked, else the header is done
  function automatic void finish_length();
    if (masked) begin
      hdr_left = wsfd_pkg::KEY_BYTES;
      mask_key = '0;
      phase    = MASKKEY;
    end else begin
      finish_header();
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic rs);
    hdr_phase_e ph;
    logic [6:0] len7;
    logic [7:0] kb;
    ph = rs ? HEAD1 : phase;
    case (ph)
      HALTED: begin
        // parser stopped: nothing until resync
      end
      HEAD2: begin
        len7     = b[6:0];
        masked   = b[7];
        len_left = '0;
        if (len7 <= wsfd_pkg::LEN7_MAX) begin
          len_left = {57'd0, len7};
          finish_length();
        end else begin
          hdr_left = (len7 == wsfd_pkg::LEN7_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                    : wsfd_pkg::EXT64_BYTES;
          phase    = EXTLEN;
        end
      end
      EXTLEN: begin
        len_left = {len_left[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) begin
          if ((len_left & ~LEN_CAP) != 64'd0) begin
            phase = HALTED;
            push_result(8'h00, 1'b0, 1'b0, 1'b1);
          end else begin
            finish_length();
          end
        end
      end
      MASKKEY: begin
        mask_key = {mask_key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) finish_header();
      end
      PAYLOAD: begin
        // key byte 0 is the first one received, i.e. the top byte of mask_key
        kb       = masked ? mask_key[8 * (3 - key_pos) +: 8] : 8'h00;
        key_pos  = key_pos + 2'd1;
        len_left = len_left - 64'd1;
        if (len_left == 64'd0) phase = HEAD1;
        push_result(b ^ kb, 1'b1, len_left == 64'd0, 1'b0);
      end
      default: begin
        // first header byte, also taken on resync from any phase
        cur_fin  = b[7];
        cur_op   = b[3:0];
        hdr_left = '0;
        len_left = '0;
        key_pos  = '0;
        if ((b & wsfd_pkg::RSV_MASK) != 8'h00) begin
          phase = HALTED;
          push_result(8'h00, 1'b0, 1'b0, 1'b1);
        end else begin
          phase = HEAD2;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_item(logic [7:0] b, logic rs);
    rx_item_t it;
    it.b  = b;
    it.rs = rs;
    stream_q.insert(stream_q.size(), it);
  endtask

  // One frame: header, optional extended length and key, then nbytes payload
  // bytes (fewer than the length gives a truncated frame)
  task automatic queue_frame(logic rs, logic [7:0] h1, logic msk, int form,
                             logic [63:0] len, logic [31:0] key, int nbytes);
    push_item(h1, rs);
    if (form == LEN_SHORT) begin
      push_item({msk, len[6:0]}, 1'b0);
    end else if (form == LEN_EXT16) begin
      push_item({msk, wsfd_pkg::LEN7_EXT16}, 1'b0);
      push_item(len[15:8], 1'b0);
      push_item(len[7:0], 1'b0);
    end else begin
      push_item({msk, wsfd_pkg::LEN7_EXT64}, 1'b0);
      for (int i = 7; i >= 0; i--) push_item(len[8 * i +: 8], 1'b0);
    end
    if (msk) for (int i = 3; i >= 0; i--) push_item(key[8 * i +: 8], 1'b0);
    for (int i = 0; i < nbytes; i++) push_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  function automatic logic [7:0] clean_hdr1();
    return {1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(0, 15))};
  endfunction

  task automatic build_stream();
    int          pick, lsel, form, nb, target;
    logic [63:0] len;
    bit          need_rs;
    // directed: empty ping, masked text, masked empty, reserved bits, resync
    // straight into a 16-bit length frame
    queue_frame(1'b0, 8'h89, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
    queue_frame(1'b0, 8'h81, 1'b1, LEN_SHORT, 64'd3, 32'hFF00A55A, 3);
    queue_frame(1'b0, 8'h0A, 1'b1, LEN_SHORT, 64'd0, 32'h12345678, 0);
    push_item(8'hF2, 1'b0);
    push_item(8'h7F, 1'b0);
    queue_frame(1'b1, 8'h8F, 1'b0, LEN_EXT16, 64'd1, 32'h0, 1);

    target  = stream_q.size() + RAND_ITEMS;
    need_rs = 1'b0;
    while (stream_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        // well-formed frame, mostly short
        lsel = $urandom_range(0, 99);
        if (lsel < 70) begin
          form = LEN_SHORT; len = 64'($urandom_range(0, 12));
        end else if (lsel < 75) begin
          form = LEN_SHORT; len = 64'($urandom_range(13, 125));
        end else if (lsel < 90) begin
          form = LEN_EXT16; len = 64'($urandom_range(0, 40));
        end else begin
          form = LEN_EXT64; len = 64'($urandom_range(0, 24));
        end
        queue_frame(need_rs || ($urandom_range(0, 7) == 0), clean_hdr1(),
                    1'($urandom_range(0, 1)), form, len, $urandom, int'(len));
        need_rs = 1'b0;
      end else if (pick < 82) begin
        // huge length, cut short; the next frame must resync
        if ($urandom_range(0, 1) == 0) begin
          form = LEN_EXT16; len = 64'($urandom_range(9, 65535));
        end else begin
          form = LEN_EXT64; len = {$urandom, $urandom} | 64'h10;
        end
        nb = $urandom_range(0, 8);
        queue_frame(need_rs || ($urandom_range(0, 7) == 0), clean_hdr1(),
                    1'($urandom_range(0, 1)), form, len, $urandom, nb);
        need_rs = 1'b1;
      end else if (pick < 90) begin
        // reserved bits set, then bytes the block ignores
        push_item({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                   4'($urandom_range(0, 15))}, need_rs);
        nb = $urandom_range(0, 4);
        for (int i = 0; i < nb; i++) push_item(8'($urandom_range(0, 255)), 1'b0);
        need_rs = 1'b1;
      end else begin
        // raw noise, random resync marks
        nb = $urandom_range(1, 6);
        for (int i = 0; i < nb; i++)
          push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
        need_rs = 1'b1;
      end
    end
  endtask

  function automatic bit take_break();
    if (cyc >= CALM_FROM && cyc < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: new beat at the falling edge once the previous one went in
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (stream_q.size() > 0 && !take_break()) begin
        it = stream_q.pop_front();
        in_valid <= 1'b1;
        in_byte  <= it.b;
        resync   <= it.rs;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to fill both result stages
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= !take_break();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results, then feed the accepted byte to the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    wsfd_pkg::res_t exp_r;
    in_took <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: payload %0h has %0b end %0b err %0b",
               payload_byte, has_byte, frame_end, frame_error);
        mismatches++;
      end else begin
        exp_r = expected_beats.pop_front();
        if (payload_byte !== exp_r.payload) begin
          $error("payload_byte: expected %0h, got %0h", exp_r.payload, payload_byte);
          mismatches++;
        end
        if (has_byte !== exp_r.has) begin
          $error("has_byte: expected %0b, got %0b", exp_r.has, has_byte);
          mismatches++;
        end
        if (frame_end !== exp_r.last) begin
          $error("frame_end: expected %0b, got %0b", exp_r.last, frame_end);
          mismatches++;
        end
        if (frame_opcode !== exp_r.opcode) begin
          $error("frame_opcode: expected %0h, got %0h", exp_r.opcode, frame_opcode);
          mismatches++;
        end
        if (fin_flag !== exp_r.fin) begin
          $error("fin_flag: expected %0b, got %0b", exp_r.fin, fin_flag);
          mismatches++;
        end
        if (frame_error !== exp_r.err) begin
          $error("frame_error: expected %0b, got %0b", exp_r.err, frame_error);
          mismatches++;
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      bytes_taken <= bytes_taken + 1;
      deframe_byte(in_byte, resync);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cyc, expected_beats.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, stream everything, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    build_stream();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (stream_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/wsfd_pkg.sv
hw/rtl/websocket_frame_deframer.sv
hw/rtl/wsfd_checker.sv
tb/websocket_frame_deframer_tb.sv
